>>> hw/rtl/zgbs_pkg.sv
// ----------------------------------------------------------------------------
// zgbs_pkg: shared types and constants for the zone grid box smoother
// Item formats, grid limits and the truncating neighborhood-mean helper.
// ----------------------------------------------------------------------------
`default_nettype none

package zgbs_pkg;

  localparam int MAX_ZONES = 16;
  localparam int ZONE_W    = 16;             // Q8.8 zone value
  localparam int POS_W     = 4;              // row / column index
  localparam int SIDE_W    = 5;              // zones_per_side register
  localparam int COL_W     = 18;             // sum of up to three rows
  localparam int SUM_W     = 20;             // sum of up to nine zones
  localparam int LINE_W    = 2 * ZONE_W;     // line buffer entry: two rows

  localparam logic [SIDE_W-1:0] SIDE_RESET = 5'd8;
  localparam logic [SIDE_W-1:0] SIDE_MIN   = 5'd2;
  localparam logic [SIDE_W-1:0] SIDE_MAX   = 5'(MAX_ZONES);

  // 99.0 in Q8.8
  localparam logic [ZONE_W-1:0] MIN_START = 16'h6300;

  // reciprocal multiply constants, exact for the sum ranges used here
  localparam int RECIP_9_W  = 21;
  localparam int RECIP_9_SH = 24;
  localparam logic [RECIP_9_W-1:0] RECIP_9 = 21'd1864136;   // ceil(2^24 / 9)
  localparam int RECIP_3_W  = 19;
  localparam int RECIP_3_SH = 20;
  localparam logic [RECIP_3_W-1:0] RECIP_3 = 19'd349526;    // ceil(2^20 / 3)

  // result queue
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = 2;
  localparam int RQ_CNT_W = 3;

  typedef struct packed {
    logic [ZONE_W-1:0] zone_value;
    logic              grid_start;
  } in_item_t;

  typedef struct packed {
    logic [ZONE_W-1:0] smoothed_value;
    logic [POS_W-1:0]  zone_row;
    logic [POS_W-1:0]  zone_col;
    logic              last_of_grid;
    logic [ZONE_W-1:0] grid_minimum;
    logic [ZONE_W-1:0] grid_maximum;
  } out_item_t;

  // one smoothed zone on its way to the output register
  typedef struct packed {
    logic [ZONE_W-1:0] smoothed_value;
    logic [POS_W-1:0]  zone_row;
    logic [POS_W-1:0]  zone_col;
    logic              last_of_grid;
  } res_t;

  // which of the two result slots are written this cycle (a before b)
  typedef struct packed {
    logic a;
    logic b;
  } push_t;

  // truncated mean of a 2x2, 2x3, 3x2 or 3x3 neighborhood sum
  function automatic logic [ZONE_W-1:0] box_mean(input logic [SUM_W-1:0] sum,
                                                 input logic rows3,
                                                 input logic cols3);
    logic [SUM_W+RECIP_9_W-1:0]   p9;
    logic [SUM_W-1+RECIP_3_W-1:0] p3;
    logic [ZONE_W-1:0]            q;
    p9 = (SUM_W+RECIP_9_W)'(sum) * (SUM_W+RECIP_9_W)'(RECIP_9);
    p3 = (SUM_W-1+RECIP_3_W)'(sum[SUM_W-1:1]) * (SUM_W-1+RECIP_3_W)'(RECIP_3);
    unique case ({rows3, cols3})
      2'b11:        q = p9[RECIP_9_SH +: ZONE_W];
      2'b10, 2'b01: q = p3[RECIP_3_SH +: ZONE_W];    // (sum/2)/3
      2'b00:        q = sum[ZONE_W+1:2];
    endcase
    return q;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/zgbs_ram.sv
// ----------------------------------------------------------------------------
// zgbs_ram: generic simple dual-port RAM
// One write port, one read port with registered read data (old data on collision).
// ----------------------------------------------------------------------------
`default_nettype none

module zgbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/zgbs_out_stage.sv
// ----------------------------------------------------------------------------
// zgbs_out_stage: result queue and output register
// Buffers up to two results per cycle, tracks grid min/max in output order.
// ----------------------------------------------------------------------------
`default_nettype none

module zgbs_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  zgbs_pkg::push_t     push,
  input  zgbs_pkg::res_t      res_a,
  input  zgbs_pkg::res_t      res_b,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output zgbs_pkg::out_item_t out_item
);
  import zgbs_pkg::*;

  res_t                queue [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_ptr;
  logic [RQ_PTR_W-1:0] rd_ptr;
  logic [RQ_CNT_W-1:0] count;
  logic [1:0]          push_n;
  logic                pop;
  res_t                head;
  logic                grid_first;
  logic [ZONE_W-1:0]   running_min;
  logic [ZONE_W-1:0]   running_max;
  logic [ZONE_W-1:0]   base_min;
  logic [ZONE_W-1:0]   base_max;
  logic [ZONE_W-1:0]   min_next;
  logic [ZONE_W-1:0]   max_next;

  assign push_n = {push.a & push.b, push.a ^ push.b};
  assign room   = count <= RQ_CNT_W'(RQ_DEPTH - 2);
  assign pop    = (count != '0) && (!out_valid || !out_stall);
  assign head   = queue[rd_ptr];

  // zone (0,0) is always the first result of a grid: min/max restart there
  assign grid_first = (head.zone_row == '0) && (head.zone_col == '0);

  always_comb begin
    base_min = grid_first ? MIN_START : running_min;
    base_max = grid_first ? '0 : running_max;
    min_next = (head.smoothed_value < base_min) ? head.smoothed_value : base_min;
    max_next = (head.smoothed_value > base_max && head.smoothed_value < MIN_START) ?
               head.smoothed_value : base_max;
  end

  always_ff @(posedge clk) begin
    if (push.a) begin
      queue[wr_ptr] <= res_a;
    end
    if (push.b) begin
      queue[push.a ? wr_ptr + RQ_PTR_W'(1) : wr_ptr] <= res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      count       <= '0;
      out_valid   <= 1'b0;
      running_min <= MIN_START;
      running_max <= '0;
    end else begin
      wr_ptr <= wr_ptr + RQ_PTR_W'(push_n);
      rd_ptr <= rd_ptr + RQ_PTR_W'(pop);
      count  <= count + RQ_CNT_W'(push_n) - RQ_CNT_W'(pop);
      if (pop) begin
        out_valid   <= 1'b1;
        running_min <= min_next;
        running_max <= max_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item.smoothed_value <= head.smoothed_value;
      out_item.zone_row       <= head.zone_row;
      out_item.zone_col       <= head.zone_col;
      out_item.last_of_grid   <= head.last_of_grid;
      out_item.grid_minimum   <= head.last_of_grid ? min_next : '0;
      out_item.grid_maximum   <= head.last_of_grid ? max_next : '0;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/zone_grid_box_smoother_core.sv
// ----------------------------------------------------------------------------
// zone_grid_box_smoother_core: 3x3 normalized box filter over a zone grid
// Takes Q8.8 zones in raster order, emits each zone's truncated neighborhood
// mean (divisor 9 / 6 / 4) with grid min/max on the final result.
//
// Input channel (in_valid / in_stall / in_item): one zone per transaction,
// grid_start restarts the grid at zone (0,0). Output channel (out_valid /
// out_stall / out_item): results in raster order of the smoothed zone.
// Config channel (cfg_valid / cfg_ready / cfg_data) writes zones_per_side and
// restarts the grid; cfg_ready is always high, write only while idle.
// Throughput: one zone per cycle. The last zone of a grid starts a flush of
// the bottom row that holds in_stall high while one readback per grid column
// (the clamped side, 2 to 16) reads the line buffer back.
// After the transaction that completes its neighborhood, a result passes the
// line buffer read, column sums, box sums and result queue to the output register.
// When out_stall is held, a 4-entry result queue fills and in_stall rises.
// Reset: zones_per_side = 8, position (0,0), pipeline and queue empty. The
// line buffer is not cleared; only entries written in the current grid are used.
// ----------------------------------------------------------------------------
`default_nettype none

module zone_grid_box_smoother_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  zgbs_pkg::in_item_t          in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output zgbs_pkg::out_item_t         out_item,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [zgbs_pkg::SIDE_W-1:0] cfg_data
);
  import zgbs_pkg::*;

  typedef enum logic [1:0] {
    ST_STREAM = 2'b01,
    ST_FLUSH  = 2'b10
  } flow_state_t;

  // column transaction entering the window
  typedef struct packed {
    logic              flush;      // bottom-row readback, no new zone
    logic              emit_en;
    logic              rows3;
    logic              last_col;
    logic              grid_end;
    logic [POS_W-1:0]  row;        // row of the zones smoothed by this column
    logic [POS_W-1:0]  col;
    logic [ZONE_W-1:0] value;
  } col_in_t;

  typedef struct packed {
    logic             emit_en;
    logic             rows3;
    logic             last_col;
    logic             grid_end;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } col_evt_t;

  typedef struct packed {
    logic             a_en;
    logic             b_en;
    logic             rows3;
    logic             cols3_a;
    logic [SUM_W-1:0] sum_a;
    logic [SUM_W-1:0] sum_b;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             grid_end;
  } box_t;

  flow_state_t       state;
  logic [SIDE_W-1:0] zones_per_side;
  logic [SIDE_W-1:0] side_n;
  logic [SIDE_W-1:0] side_dec;
  logic [POS_W-1:0]  side_m1;
  logic [POS_W-1:0]  in_row;
  logic [POS_W-1:0]  in_col;
  logic [POS_W-1:0]  cur_row;
  logic [POS_W-1:0]  cur_col;
  logic [POS_W-1:0]  flush_col;
  logic              pos_restart;
  logic              grid_last;
  logic              col_wrap;
  logic              adv;
  logic              accept;
  logic              flush_issue;
  logic              issue;

  col_in_t           s1_next;
  col_in_t           s1;
  logic              s1_valid;
  col_evt_t          s2;
  logic              s2_valid;
  box_t              s3_next;
  box_t              s3;
  logic              s3_valid;

  logic [LINE_W-1:0] rd_data;
  logic [ZONE_W-1:0] rd_hi;
  logic [ZONE_W-1:0] rd_lo;
  logic              ram_we;
  logic [POS_W-1:0]  ram_raddr;
  logic [COL_W-1:0]  col_sum;
  logic [COL_W-1:0]  h0;
  logic [COL_W-1:0]  h1;
  logic [COL_W-1:0]  h2;

  push_t             push;
  res_t              res_a;
  res_t              res_b;

  assign cfg_ready = 1'b1;

  always_comb begin
    priority if (zones_per_side < SIDE_MIN) begin
      side_n = SIDE_MIN;
    end else if (zones_per_side > SIDE_MAX) begin
      side_n = SIDE_MAX;
    end else begin
      side_n = zones_per_side;
    end
  end
  assign side_dec = side_n - SIDE_W'(1);
  assign side_m1  = side_dec[POS_W-1:0];

  // ---- input position ----
  assign pos_restart = in_item.grid_start || ({1'b0, in_row} >= side_n) ||
                       ({1'b0, in_col} >= side_n);
  assign cur_row   = pos_restart ? '0 : in_row;
  assign cur_col   = pos_restart ? '0 : in_col;
  assign col_wrap  = cur_col == side_m1;
  assign grid_last = (cur_row == side_m1) && col_wrap;

  assign in_stall    = !(adv && state == ST_STREAM);
  assign accept      = in_valid && !in_stall;
  assign flush_issue = adv && state == ST_FLUSH;
  assign issue       = accept || flush_issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_STREAM;
      zones_per_side <= SIDE_RESET;
      in_row         <= '0;
      in_col         <= '0;
      flush_col      <= '0;
    end else begin
      unique case (state)
        ST_STREAM: begin
          if (accept && grid_last) begin
            state     <= ST_FLUSH;
            flush_col <= '0;
          end
        end
        ST_FLUSH: begin
          if (adv) begin
            flush_col <= flush_col + POS_W'(1);
            if (flush_col == side_m1) begin
              state <= ST_STREAM;
            end
          end
        end
      endcase
      if (accept) begin
        if (grid_last) begin
          in_row <= '0;
          in_col <= '0;
        end else if (col_wrap) begin
          in_row <= cur_row + POS_W'(1);
          in_col <= '0;
        end else begin
          in_row <= cur_row;
          in_col <= cur_col + POS_W'(1);
        end
      end
      if (cfg_valid && cfg_ready) begin
        zones_per_side <= cfg_data;
        in_row         <= '0;
        in_col         <= '0;
      end
    end
  end

  // ---- stage 1: line buffer read ----
  always_comb begin
    if (state == ST_FLUSH) begin
      s1_next.flush    = 1'b1;
      s1_next.emit_en  = 1'b1;
      s1_next.rows3    = 1'b0;
      s1_next.last_col = flush_col == side_m1;
      s1_next.grid_end = flush_col == side_m1;
      s1_next.row      = side_m1;
      s1_next.col      = flush_col;
      s1_next.value    = '0;
    end else begin
      s1_next.flush    = 1'b0;
      s1_next.emit_en  = cur_row != '0;
      s1_next.rows3    = cur_row >= POS_W'(2);
      s1_next.last_col = col_wrap;
      s1_next.grid_end = 1'b0;
      s1_next.row      = cur_row - POS_W'(1);
      s1_next.col      = cur_col;
      s1_next.value    = in_item.zone_value;
    end
  end

  assign ram_raddr = (state == ST_FLUSH) ? flush_col : cur_col;
  assign ram_we    = adv && s1_valid && !s1.flush;

  // entry per column: {row r-1, row r-2}; each new zone pushes the pair down
  zgbs_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_ZONES)
  ) u_line_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1.col),
    .wdata ({s1.value, rd_hi}),
    .re    (issue),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  assign rd_hi = rd_data[LINE_W-1:ZONE_W];
  assign rd_lo = rd_data[ZONE_W-1:0];

  // vertical sum; flush readback holds the bottom two rows
  always_comb begin
    logic [ZONE_W-1:0] bot;
    logic [ZONE_W-1:0] mid;
    logic [ZONE_W-1:0] top;
    bot     = s1.flush ? rd_hi : s1.value;
    mid     = s1.flush ? rd_lo : rd_hi;
    top     = s1.rows3 ? rd_lo : '0;
    col_sum = COL_W'(bot) + COL_W'(mid) + COL_W'(top);
  end

  // ---- stage 3 inputs: horizontal sums over the column window ----
  always_comb begin
    logic wide;
    wide             = s2.col >= POS_W'(2);
    s3_next.a_en     = s2.emit_en && (s2.col != '0);
    s3_next.b_en     = s2.emit_en && s2.last_col;
    s3_next.rows3    = s2.rows3;
    s3_next.cols3_a  = wide;
    s3_next.sum_a    = SUM_W'(h0) + SUM_W'(h1) + (wide ? SUM_W'(h2) : '0);
    s3_next.sum_b    = SUM_W'(h0) + SUM_W'(h1);
    s3_next.row      = s2.row;
    s3_next.col      = s2.col;
    s3_next.grid_end = s2.grid_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1          <= s1_next;
      s2.emit_en  <= s1.emit_en;
      s2.rows3    <= s1.rows3;
      s2.last_col <= s1.last_col;
      s2.grid_end <= s1.grid_end;
      s2.row      <= s1.row;
      s2.col      <= s1.col;
      s3          <= s3_next;
      if (s1_valid) begin
        h0 <= col_sum;
        h1 <= h0;
        h2 <= h1;
      end
    end
  end

  // ---- stage 4: means into the result queue ----
  assign push.a = adv && s3_valid && s3.a_en;
  assign push.b = adv && s3_valid && s3.b_en;

  assign res_a.smoothed_value = box_mean(s3.sum_a, s3.rows3, s3.cols3_a);
  assign res_a.zone_row       = s3.row;
  assign res_a.zone_col       = s3.col - POS_W'(1);
  assign res_a.last_of_grid   = 1'b0;

  assign res_b.smoothed_value = box_mean(s3.sum_b, s3.rows3, 1'b0);
  assign res_b.zone_row       = s3.row;
  assign res_b.zone_col       = s3.col;
  assign res_b.last_of_grid   = s3.grid_end;

  zgbs_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .res_a     (res_a),
    .res_b     (res_b),
    .room      (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
